### rtl/sha1ds_pkg.sv
// ----------------------------------------------------------------------------
// sha1ds_pkg
// Shared types and constants of the streaming SHA-1 engine: round constants,
// initial chaining words, padding constants, sequencer states.
// ----------------------------------------------------------------------------
package sha1ds_pkg;

    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    localparam logic [31:0] INIT_H [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [6:0] ROUND_20   = 7'd20;
    localparam logic [6:0] ROUND_40   = 7'd40;
    localparam logic [6:0] ROUND_60   = 7'd60;
    localparam logic [6:0] LAST_ROUND = 7'd79;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [2:0] LAST_INDEX = 3'd4;

    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_vars;

endpackage

### rtl/sha1_digest_stream.sv
// ----------------------------------------------------------------------------
// sha1_digest_stream
// Streaming SHA-1 engine: absorbs message bytes, pads on finish and returns
// the 160-bit digest as five 32-bit words, most significant first.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | i_valid / o_ready  | i_func, i_data_byte
//  out     | output    | o_valid / i_ready  | o_digest_word, o_word_index,
//          |           |                    | o_last_word
//
//  Absorb bytes are taken only while idle; the byte that fills the 64-byte
//  block starts a compression of 80 single-round steps in the shared round
//  unit plus one chaining add. A finish pads with 9 to 72 bytes, runs one or
//  two compressions, then emits the five digest words.
//  Reset is synchronous; no clearing pass.
//  o_ready is high only while idle; the output stalls while i_ready is low.
// ----------------------------------------------------------------------------
module sha1_digest_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sha1ds_pkg::t_state r_state, n_state;
    logic [5:0]         r_fill, n_fill;
    logic [60:0]        r_count, n_count;
    logic [23:0]        r_part, n_part;
    logic [31:0]        r_w [16];
    logic [31:0]        n_w [16];
    logic [31:0]        r_h [5];
    logic [31:0]        n_h [5];
    sha1ds_pkg::t_vars  r_v, n_v;
    logic [6:0]         r_rnd, n_rnd;
    logic               r_mark, n_mark;
    logic               r_len, n_len;
    logic               r_fin, n_fin;
    logic               r_last, n_last;
    logic [2:0]         r_idx, n_idx;

    logic               w_in_acc;
    logic               w_len_phase;
    logic [63:0]        w_bits;
    logic [7:0]         w_pad;
    logic               w_push;
    logic [7:0]         w_byte;
    logic [31:0]        w_sched_x;
    sha1ds_pkg::t_vars  w_h_vars;
    sha1ds_pkg::t_vars  w_round_out;

    assign o_ready       = (r_state == sha1ds_pkg::S_IDLE);
    assign o_valid       = (r_state == sha1ds_pkg::S_EMIT);
    assign o_digest_word = r_h[0];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == sha1ds_pkg::LAST_INDEX);

    assign w_in_acc    = i_valid && o_ready;
    assign w_len_phase = r_mark && (r_len || (r_fill == sha1ds_pkg::LEN_POS));
    assign w_bits      = {r_count, 3'b000};
    assign w_sched_x   = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_h_vars    = '{a: r_h[0], b: r_h[1], c: r_h[2], d: r_h[3], e: r_h[4]};

    always_comb begin
        if (!r_mark) begin
            w_pad = sha1ds_pkg::PAD_MARK;
        end else if (w_len_phase) begin
            w_pad = w_bits[{~r_fill[2:0], 3'b000} +: 8];
        end else begin
            w_pad = 8'h00;
        end
    end

    assign w_push = (w_in_acc && (i_func == sha1ds_pkg::FUNC_ABSORB))
                    || (r_state == sha1ds_pkg::S_PAD);
    assign w_byte = (r_state == sha1ds_pkg::S_PAD) ? w_pad : i_data_byte;

    sha1ds_round u_round (
        .i_vars  (r_v),
        .i_sched (r_w[0]),
        .i_round (r_rnd),
        .o_vars  (w_round_out)
    );

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_count = r_count;
        n_part  = r_part;
        n_w     = r_w;
        n_h     = r_h;
        n_v     = r_v;
        n_rnd   = r_rnd;
        n_mark  = r_mark;
        n_len   = r_len;
        n_fin   = r_fin;
        n_last  = r_last;
        n_idx   = r_idx;

        case (r_state)
            sha1ds_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (i_func == sha1ds_pkg::FUNC_FINISH) begin
                        n_state = sha1ds_pkg::S_PAD;
                        n_fin   = 1'b1;
                    end else begin
                        n_count = r_count + 61'd1;
                    end
                end
            end
            sha1ds_pkg::S_PAD: begin
                n_mark = 1'b1;
                if (w_len_phase) begin
                    n_len = 1'b1;
                end
                n_last = w_len_phase && (r_fill == sha1ds_pkg::BLOCK_LAST);
            end
            sha1ds_pkg::S_ROUND: begin
                n_v   = w_round_out;
                n_rnd = r_rnd + 7'd1;
                for (int k = 0; k < 15; k++) begin
                    n_w[k] = r_w[k + 1];
                end
                n_w[15] = {w_sched_x[30:0], w_sched_x[31]};
                if (r_rnd == sha1ds_pkg::LAST_ROUND) begin
                    n_state = sha1ds_pkg::S_ADD;
                end
            end
            sha1ds_pkg::S_ADD: begin
                n_h[0] = r_h[0] + r_v.a;
                n_h[1] = r_h[1] + r_v.b;
                n_h[2] = r_h[2] + r_v.c;
                n_h[3] = r_h[3] + r_v.d;
                n_h[4] = r_h[4] + r_v.e;
                if (r_last) begin
                    n_state = sha1ds_pkg::S_EMIT;
                end else if (r_fin) begin
                    n_state = sha1ds_pkg::S_PAD;
                end else begin
                    n_state = sha1ds_pkg::S_IDLE;
                end
            end
            sha1ds_pkg::S_EMIT: begin
                if (i_ready) begin
                    for (int k = 0; k < 4; k++) begin
                        n_h[k] = r_h[k + 1];
                    end
                    n_idx = r_idx + 3'd1;
                    if (r_idx == sha1ds_pkg::LAST_INDEX) begin
                        n_h     = sha1ds_pkg::INIT_H;
                        n_idx   = 3'd0;
                        n_count = '0;
                        n_mark  = 1'b0;
                        n_len   = 1'b0;
                        n_fin   = 1'b0;
                        n_last  = 1'b0;
                        n_state = sha1ds_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sha1ds_pkg::S_IDLE;
            end
        endcase

        // append one byte; a full word enters the schedule window
        if (w_push) begin
            n_part = {r_part[15:0], w_byte};
            n_fill = r_fill + 6'd1;
            if (r_fill[1:0] == 2'b11) begin
                for (int k = 0; k < 15; k++) begin
                    n_w[k] = r_w[k + 1];
                end
                n_w[15] = {r_part, w_byte};
            end
            if (r_fill == sha1ds_pkg::BLOCK_LAST) begin
                n_state = sha1ds_pkg::S_ROUND;
                n_v     = w_h_vars;
                n_rnd   = 7'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1ds_pkg::S_IDLE;
            r_fill  <= '0;
            r_count <= '0;
            r_h     <= sha1ds_pkg::INIT_H;
            r_rnd   <= '0;
            r_mark  <= 1'b0;
            r_len   <= 1'b0;
            r_fin   <= 1'b0;
            r_last  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_count <= n_count;
            r_h     <= n_h;
            r_rnd   <= n_rnd;
            r_mark  <= n_mark;
            r_len   <= n_len;
            r_fin   <= n_fin;
            r_last  <= n_last;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_part <= n_part;
        r_w    <= n_w;
        r_v    <= n_v;
    end

`ifndef SYNTHESIS
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha1ds_pkg::S_ROUND) |-> (r_rnd <= sha1ds_pkg::LAST_ROUND))
        else $error("round counter out of range");

    a_block_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_func == sha1ds_pkg::FUNC_ABSORB)
         && (r_fill == sha1ds_pkg::BLOCK_LAST))
        |=> ((r_state == sha1ds_pkg::S_ROUND) && (r_rnd == 7'd0) && (r_fill == 6'd0)))
        else $error("full block did not start compression");

    a_emit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ((o_word_index == 3'd0) && (r_fill == 6'd0) && r_len))
        else $error("digest emitted before padding completed");

    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word_index <= sha1ds_pkg::LAST_INDEX))
        else $error("digest word index out of range");
`endif

endmodule

### rtl/sha1ds_round.sv
// ----------------------------------------------------------------------------
// sha1ds_round
// One SHA-1 compression round: selects the round function and constant from
// the round number and produces the next five working variables.
// ----------------------------------------------------------------------------
module sha1ds_round (
    input  sha1ds_pkg::t_vars i_vars,
    input  logic [31:0]       i_sched,
    input  logic [6:0]        i_round,
    output sha1ds_pkg::t_vars o_vars
);

    logic [31:0] w_f;
    logic [31:0] w_k;
    logic [31:0] w_sum;

    always_comb begin
        if (i_round < sha1ds_pkg::ROUND_20) begin
            w_f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            w_k = sha1ds_pkg::K_0;
        end else if (i_round < sha1ds_pkg::ROUND_40) begin
            w_f = i_vars.b ^ i_vars.c ^ i_vars.d;
            w_k = sha1ds_pkg::K_1;
        end else if (i_round < sha1ds_pkg::ROUND_60) begin
            w_f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
            w_k = sha1ds_pkg::K_2;
        end else begin
            w_f = i_vars.b ^ i_vars.c ^ i_vars.d;
            w_k = sha1ds_pkg::K_3;
        end
        w_sum = {i_vars.a[26:0], i_vars.a[31:27]} + w_f + i_vars.e + w_k + i_sched;
        o_vars.a = w_sum;
        o_vars.b = i_vars.a;
        o_vars.c = {i_vars.b[1:0], i_vars.b[31:2]};
        o_vars.d = i_vars.c;
        o_vars.e = i_vars.d;
    end

endmodule
